// ===== hw/rtl/mvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  localparam int DATA_W      = 32;
  localparam int CFG_W       = 64;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_COLS    = 4;
  localparam int NUM_ROWS    = 4;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  // Pipeline stages: operand, multiply, pair sum, total, shift and clamp
  localparam int NUM_STAGES = 5;
  localparam int STG_OPND   = 0;
  localparam int STG_MUL    = 1;
  localparam int STG_PAIR   = 2;
  localparam int STG_SUM    = 3;
  localparam int STG_OUT    = 4;

  localparam logic CMD_VEC4  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // Identity matrix in Q16.16
  localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = {
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
    logic signed [DATA_W-1:0] in_w;
  } vtx_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     saturated;
  } vtx_out_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mvt_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_cfg_regs import mvt_pkg::*; (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [CFG_W-1:0]               cfg_wdata_i,
  output logic      [NUM_REGS-1:0][CFG_W-1:0] regs_o
);

  logic [NUM_REGS-1:0][CFG_W-1:0] regs_q;

  // Drop writes past the last register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CFG_RESET;
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_index_i[$clog2(NUM_REGS)-1:0]] <= cfg_wdata_i;
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mvt_pipe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_pipe_ctrl import mvt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic point_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output pipe_ctl_t ctl_o,
  output logic      point_o
);

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] pt_q;
  logic [NUM_STAGES:0]   ready;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    ready[NUM_STAGES] = !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !vld_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ready[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      pt_q[0] <= point_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (ready[k]) begin
        pt_q[k] <= pt_q[k-1];
      end
    end
  end

  assign ctl_o.en    = ready[NUM_STAGES-1:0];
  assign in_stall_o  = !ready[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign point_o     = pt_q[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/mvt_row_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_row_dot import mvt_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int OpW = (ELEM_WIDTH > FRAC_BITS + 2) ? ELEM_WIDTH : FRAC_BITS + 2
) (
  input  wire logic                           clk_i,
  input  wire pipe_ctl_t                      ctl_i,
  input  wire logic signed [OpW-1:0]          vec_i [NUM_COLS],
  input  wire logic signed [ELEM_WIDTH-1:0]   col_i [NUM_COLS],
  output logic signed      [DATA_W-1:0]       res_o,
  output logic                                sat_o
);

  localparam int PW = 2 * OpW;
  localparam int SW = PW + 2;

  logic signed [OpW-1:0]  col_ext [NUM_COLS];
  logic signed [PW-1:0]   prod_q  [NUM_COLS];
  logic signed [PW:0]     pair_q  [2];
  logic signed [SW-1:0]   total_q;
  logic signed [SW-1:0]   shifted;
  logic signed [ELEM_WIDTH-1:0] clamped;
  logic signed [DATA_W-1:0]     res_d;
  logic                         sat_d;
  logic [SW-ELEM_WIDTH:0]       top_bits;

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      col_ext[c] = OpW'(col_i[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_MUL]) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod_q[c] <= vec_i[c] * col_ext[c];
      end
    end
    if (ctl_i.en[STG_PAIR]) begin
      pair_q[0] <= prod_q[0] + prod_q[1];
      pair_q[1] <= prod_q[2] + prod_q[3];
    end
    if (ctl_i.en[STG_SUM]) begin
      total_q <= pair_q[0] + pair_q[1];
    end
    if (ctl_i.en[STG_OUT]) begin
      res_o <= res_d;
      sat_o <= sat_d;
    end
  end

  // Floor shift, then clamp when the bits above the element sign disagree
  always_comb begin
    shifted  = total_q >>> FRAC_BITS;
    top_bits = shifted[SW-1:ELEM_WIDTH-1];
    sat_d    = !((&top_bits) || !(|top_bits));
    if (!sat_d) begin
      clamped = shifted[ELEM_WIDTH-1:0];
    end else if (shifted[SW-1]) begin
      clamped = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    end else begin
      clamped = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end
    res_d = DATA_W'(clamped);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_vector_transform_4x4.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages, in order: operand, multiply, pair sum, total, clamp; the operand stage
// registers the item at the edge that accepts it. Throughput: one item per cycle
// unless out_stall_i backs up to in_stall_o; sixteen parallel multipliers, one
// per element. Reset: asynchronous, active low; empties the pipeline and loads
// the identity matrix into the eight column registers.

module matrix_vector_transform_4x4 import mvt_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire vtx_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output vtx_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  // Operand width: wide enough for every element and for 1.0 in point mode
  localparam int OpW = (ELEM_WIDTH > FRAC_BITS + 2) ? ELEM_WIDTH : FRAC_BITS + 2;
  localparam int SlotW = CFG_W / 2;

  logic [NUM_REGS-1:0][CFG_W-1:0] regs;
  pipe_ctl_t                      ctl;
  logic                           point_out;

  logic signed [OpW-1:0]          vec_d [NUM_COLS];
  logic signed [OpW-1:0]          vec_q [NUM_COLS];
  logic signed [ELEM_WIDTH-1:0]   elem  [NUM_ROWS][NUM_COLS];
  logic signed [DATA_W-1:0]       row_res [NUM_ROWS];
  logic [NUM_ROWS-1:0]            row_sat;

  // Column registers
  mvt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .regs_o      (regs)
  );

  // Valid bits, stage enables and the point tag travel here
  mvt_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .point_i     (in_data_i.command == CMD_POINT),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .point_o     (point_out)
  );

  // Keep the low element bits of each component as a signed value; point mode
  // replaces w by 1.0 in the configured format.
  always_comb begin
    logic signed [ELEM_WIDTH-1:0] ex, ey, ez, ew;
    ex = in_data_i.in_x[ELEM_WIDTH-1:0];
    ey = in_data_i.in_y[ELEM_WIDTH-1:0];
    ez = in_data_i.in_z[ELEM_WIDTH-1:0];
    ew = in_data_i.in_w[ELEM_WIDTH-1:0];
    vec_d[0] = OpW'(ex);
    vec_d[1] = OpW'(ey);
    vec_d[2] = OpW'(ez);
    if (in_data_i.command == CMD_POINT) begin
      vec_d[3] = OpW'(1) << FRAC_BITS;
    end else begin
      vec_d[3] = OpW'(ew);
    end
  end

  // Operand stage
  always_ff @(posedge clk_i) begin
    if (ctl.en[STG_OPND]) begin
      vec_q <= vec_d;
    end
  end

  // Pick each element out of its 32-bit slot: row pairs share a register
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        elem[r][c] = regs[2*c + r/2][(r%2)*SlotW +: ELEM_WIDTH];
      end
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    mvt_row_dot #(
      .FRAC_BITS  (FRAC_BITS),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_row (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .vec_i (vec_q),
      .col_i (elem[r]),
      .res_o (row_res[r]),
      .sat_o (row_sat[r])
    );
  end

  // Point mode: drop row 3 from the result and from the clamp flag
  assign out_data_o.out_x     = row_res[0];
  assign out_data_o.out_y     = row_res[1];
  assign out_data_o.out_z     = row_res[2];
  assign out_data_o.out_w     = point_out ? '0 : row_res[3];
  assign out_data_o.saturated = (|row_sat[2:0]) || (!point_out && row_sat[3]);

endmodule

`default_nettype wire

// ===== tb/tb_matrix_vector_transform_4x4.sv =====
`timescale 1ns / 1ps

module tb_matrix_vector_transform_4x4 import mvt_pkg::*; ();

  // Fixed-point format of the block under test (default parameters)
  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int ELEM_W = ELEM_WIDTH_DEF;

  localparam logic [31:0] Q_ONE   = 32'd1 << FRAC;
  localparam logic [31:0] MAXV    = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV    = 32'h8000_0000;
  localparam logic [31:0] NEG_ULP = 32'hFFFF_FFFF;

  // Register indexes written by name in the directed part
  localparam int REG_COL0_ROWS01 = 0;
  localparam int REG_COL0_ROWS23 = 1;
  localparam int CFG_IDX_LAST    = (1 << CFG_IDX_W) - 1;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int QUIET_LIMIT     = 2000;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_e;
  typedef enum int {W_SMALL, W_FULL, W_EDGE, W_MIX} word_mix_e;
  typedef enum int {MAT_IDENT, MAT_SMALL, MAT_FULL, MAT_MAX, MAT_MIN, MAT_MIX} mat_kind_e;

  // One line of the directed plan: a register write, or a vertex with either
  // a hand-typed result or one taken from the transform predictor.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    vtx_in_t              vin;
    vtx_out_t             want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  vtx_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vtx_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the eight column registers, used by the predictor
  logic [CFG_W-1:0] mtx_regs [NUM_REGS];
  // Transformed vertices still owed by the block, oldest first
  vtx_out_t         pending_xforms [$];
  plan_row_t        plan [$];
  int               mismatches = 0;
  int               quiet_cycles = 0;
  bit               gaps_on = 1'b1;

  matrix_vector_transform_4x4 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sign-extend the low ELEM_W bits of a 32-bit slot
  function automatic longint elem_value(logic [31:0] slot);
    return 64'(signed'(slot[ELEM_W-1:0]));
  endfunction

  // Identity matrix, column-major: diagonal element of column c lives in
  // register 2c + c/2, in the high half for odd c.
  function automatic logic [CFG_W-1:0] ident_reg(int r);
    int col;
    col = r / 2;
    if ((r % 2) != (col / 2)) return '0;
    return (col % 2) ? {Q_ONE, 32'h0} : {32'h0, Q_ONE};
  endfunction

  // Exact dot product per row, floor shift, clamp to ELEM_W bits.
  // Point form forces w to 1.0, skips row 3 and leaves out_w at zero.
  function automatic vtx_out_t transform_vertex(vtx_in_t vin);
    longint             vec [4];
    logic signed [67:0] acc;
    logic signed [67:0] top;
    logic signed [67:0] bottom;
    logic [31:0]        rows [4];
    logic [CFG_W-1:0]   r;
    logic [31:0]        slot;
    int                 n_rows;
    logic               sat;
    vtx_out_t           res;
    vec[0] = elem_value(vin.in_x);
    vec[1] = elem_value(vin.in_y);
    vec[2] = elem_value(vin.in_z);
    vec[3] = (vin.command == CMD_POINT) ? (longint'(1) <<< FRAC) : elem_value(vin.in_w);
    n_rows = (vin.command == CMD_POINT) ? 3 : 4;
    top    = (68'sd1 <<< (ELEM_W - 1)) - 68'sd1;
    bottom = -top - 68'sd1;
    sat    = 1'b0;
    for (int row = 0; row < 4; row++) begin
      rows[row] = '0;
      if (row < n_rows) begin
        acc = '0;
        for (int col = 0; col < 4; col++) begin
          r    = mtx_regs[2 * col + row / 2];
          slot = row[0] ? r[63:32] : r[31:0];
          acc  = acc + elem_value(slot) * vec[col];
        end
        acc = acc >>> FRAC;
        if (acc > top) begin
          acc = top;
          sat = 1'b1;
        end else if (acc < bottom) begin
          acc = bottom;
          sat = 1'b1;
        end
        rows[row] = acc[31:0];
      end
    end
    res.out_x     = rows[0];
    res.out_y     = rows[1];
    res.out_z     = rows[2];
    res.out_w     = rows[3];
    res.saturated = sat;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Small values stay within +/-8.0 so sums rarely clamp; edge values hit
  // the range limits, zero, one ulp and 1.0.
  function automatic logic [31:0] rand_word(word_mix_e mix);
    int        dice;
    word_mix_e pick;
    pick = mix;
    if (mix == W_MIX) begin
      dice = $urandom_range(0, 9);
      pick = (dice < 5) ? W_SMALL : (dice < 8) ? W_FULL : W_EDGE;
    end
    case (pick)
      W_SMALL: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      W_FULL:  return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0:       return MINV;
          1:       return MAXV;
          2:       return 32'h0;
          3:       return NEG_ULP;
          4:       return 32'h1;
          default: return Q_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic plan_row_t cfg_row(int idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx[CFG_IDX_W-1:0];
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t vtx_row(logic cmd, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] w);
    plan_row_t row;
    row             = '0;
    row.kind        = ROW_ITEM;
    row.vin.command = cmd;
    row.vin.in_x    = x;
    row.vin.in_y    = y;
    row.vin.in_z    = z;
    row.vin.in_w    = w;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic cmd, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [31:0] w,
                                          logic [31:0] ox, logic [31:0] oy,
                                          logic [31:0] oz, logic [31:0] ow, logic sat);
    plan_row_t row;
    row                = vtx_row(cmd, x, y, z, w);
    row.kind           = ROW_TYPED;
    row.want.out_x     = ox;
    row.want.out_y     = oy;
    row.want.out_z     = oz;
    row.want.out_w     = ow;
    row.want.saturated = sat;
    return row;
  endfunction

  // Present one vertex, hold it until accepted, then record what it owes.
  // Call at a falling edge; returns at a falling edge with valid still high.
  task automatic push_vertex(vtx_in_t v, logic typed, vtx_out_t want);
    if (gaps_on && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    pending_xforms.push_back(typed ? want : transform_vertex(v));
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed vertex, then let the pipeline run dry
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_xforms.size() != 0) @(negedge clk);
    repeat (NUM_STAGES + 3) @(negedge clk);
  endtask

  // One register write, with write enable low again before the next one.
  // Indexes past the register list are ignored by the block.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_REGS) mtx_regs[idx] = data;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, result check, watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 25);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result with the oldest owed vertex
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_xforms.size() == 0) begin
        mismatches++;
        $display("%0t: result with no vertex owed: expected none, actual %h",
                 $time, out_data);
      end else begin
        check_field("out_x", pending_xforms[0].out_x, out_data.out_x);
        check_field("out_y", pending_xforms[0].out_y, out_data.out_y);
        check_field("out_z", pending_xforms[0].out_z, out_data.out_z);
        check_field("out_w", pending_xforms[0].out_w, out_data.out_w);
        check_field("saturated", 32'(pending_xforms[0].saturated), 32'(out_data.saturated));
        void'(pending_xforms.pop_front());
      end
    end
  end

  // Count cycles in which nothing moves on any port; give up at the limit
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_matrix_vector_transform_4x4: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    vtx_in_t          v;
    mat_kind_e        kind;
    logic [CFG_W-1:0] val;

    for (int r = 0; r < NUM_REGS; r++) mtx_regs[r] = ident_reg(r);

    // Directed plan. Identity after reset: every vertex comes back unchanged,
    // and the point form zeroes w whatever in_w holds.
    plan.push_back(typed_row(CMD_VEC4, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                             32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
                             32'hFFFD_0000, 32'h0000_8000, 1'b0));
    plan.push_back(typed_row(CMD_POINT, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                             32'h1234_5678, 32'h0001_0000, 32'h0002_0000,
                             32'hFFFD_0000, 32'h0, 1'b0));
    plan.push_back(typed_row(CMD_VEC4, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b0));
    plan.push_back(typed_row(CMD_VEC4, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1'b0));
    plan.push_back(typed_row(CMD_POINT, MINV, MAXV, 32'h0, NEG_ULP,
                             MINV, MAXV, 32'h0, 32'h0, 1'b0));
    plan.push_back(typed_row(CMD_VEC4, NEG_ULP, NEG_ULP, NEG_ULP, NEG_ULP,
                             NEG_ULP, NEG_ULP, NEG_ULP, NEG_ULP, 1'b0));
    plan.push_back(typed_row(CMD_VEC4, 32'h1, 32'h2, 32'h3, 32'h4,
                             32'h1, 32'h2, 32'h3, 32'h4, 1'b0));
    // Writes past the register list must leave the identity in place
    plan.push_back(cfg_row(NUM_REGS, '1));
    plan.push_back(cfg_row(CFG_IDX_LAST, {32{2'b01}}));
    plan.push_back(typed_row(CMD_VEC4, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                             32'h0004_0000, 32'h0001_0000, 32'h0002_0000,
                             32'h0003_0000, 32'h0004_0000, 1'b0));
    // Largest positive element everywhere: clamps both ways
    for (int r = 0; r < NUM_REGS; r++) plan.push_back(cfg_row(r, {MAXV, MAXV}));
    plan.push_back(typed_row(CMD_VEC4, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 1'b1));
    plan.push_back(typed_row(CMD_VEC4, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 1'b1));
    plan.push_back(typed_row(CMD_POINT, MAXV, MAXV, MAXV, MAXV,
                             MAXV, MAXV, MAXV, 32'h0, 1'b1));
    plan.push_back(typed_row(CMD_VEC4, 32'h0, 32'h0, 32'h0, 32'h0,
                             32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    plan.push_back(vtx_row(CMD_VEC4, 32'h1, 32'h1, 32'h1, 32'h1));
    plan.push_back(vtx_row(CMD_POINT, 32'h0, 32'h0, 32'h0, MINV));
    // Most negative element everywhere: min times min is the largest product
    for (int r = 0; r < NUM_REGS; r++) plan.push_back(cfg_row(r, {MINV, MINV}));
    plan.push_back(typed_row(CMD_VEC4, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, 1'b1));
    plan.push_back(typed_row(CMD_VEC4, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, 1'b1));
    // Point with w = 1.0 lands exactly on the lower bound, no clamp
    plan.push_back(vtx_row(CMD_POINT, 32'h0, 32'h0, 32'h0, 32'h0));
    plan.push_back(vtx_row(CMD_VEC4, NEG_ULP, 32'h0, 32'h0, 32'h0));
    // +0.5 and -0.5 in column 0: odd ulps show the shift rounds down
    plan.push_back(cfg_row(REG_COL0_ROWS01, {32'hFFFF_8000, 32'h0000_8000}));
    plan.push_back(vtx_row(CMD_VEC4, 32'h1, 32'h0, 32'h0, 32'h0));
    plan.push_back(vtx_row(CMD_VEC4, NEG_ULP, 32'h0, 32'h0, 32'h0));
    plan.push_back(vtx_row(CMD_VEC4, 32'h3, 32'h0, 32'h0, 32'h0));
    plan.push_back(vtx_row(CMD_POINT, 32'h0001_0001, 32'hFFFF_0000, 32'h7FFF_0000, 32'h0));
    // Only row 3 overflows: point form must not flag it, full form must
    plan.push_back(cfg_row(REG_COL0_ROWS01, '0));
    plan.push_back(cfg_row(REG_COL0_ROWS23, {MAXV, 32'h0}));
    plan.push_back(vtx_row(CMD_POINT, MAXV, 32'h0, 32'h0, 32'h0));
    plan.push_back(vtx_row(CMD_VEC4, MAXV, 32'h0, 32'h0, 32'h0));

    // Hold reset, then release it on a falling edge
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          cfg_write(plan[i].idx, plan[i].data);
        end
        ROW_TYPED: push_vertex(plan[i].vin, 1'b1, plan[i].want);
        default:   push_vertex(plan[i].vin, 1'b0, '0);
      endcase
    end

    // Random phases, each with a fresh matrix. Phase 3 runs with no idling on
    // either side; phase 5 also drains completely halfway through.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      gaps_on = (ph != 3);
      kind    = mat_kind_e'(ph % 6);
      for (int r = 0; r < NUM_REGS; r++) begin
        case (kind)
          MAT_IDENT: val = ident_reg(r);
          MAT_MAX:   val = {MAXV, MAXV};
          MAT_MIN:   val = {MINV, MINV};
          MAT_SMALL: val = {rand_word(W_SMALL), rand_word(W_SMALL)};
          MAT_FULL:  val = {rand_word(W_FULL), rand_word(W_FULL)};
          default:   val = {rand_word(W_MIX), rand_word(W_MIX)};
        endcase
        cfg_write(CFG_IDX_W'(r), val);
      end
      cfg_write(CFG_IDX_W'(NUM_REGS + $urandom_range(0, CFG_IDX_LAST - NUM_REGS)),
                {$urandom, $urandom});

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) settle();
        v.command = $urandom_range(0, 1) ? CMD_POINT : CMD_VEC4;
        v.in_x    = rand_word(W_MIX);
        v.in_y    = rand_word(W_MIX);
        v.in_z    = rand_word(W_MIX);
        v.in_w    = rand_word(W_MIX);
        push_vertex(v, 1'b0, '0);
      end
    end

    gaps_on = 1'b1;
    settle();
    if (mismatches == 0) begin
      $display("tb_matrix_vector_transform_4x4: PASS");
    end else begin
      $display("tb_matrix_vector_transform_4x4: FAIL");
    end
    $finish;
  end

endmodule
